/* src/str_pkg.sv */
// ----------------------------------------------------------------------------
// str_pkg
// Shared codes and controller/datapath interface types of the triangle
// resampler.
// ----------------------------------------------------------------------------
package str_pkg;

  localparam logic [1:0] ACT_PREPARE  = 2'd0;
  localparam logic [1:0] ACT_WRITE    = 2'd1;
  localparam logic [1:0] ACT_READ     = 2'd2;
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_BADREQ = 2'd2;

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_OUT    = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_BAD, OP_WRITE,
    OP_P_CHK, OP_P_SUP, OP_P_TAPS, OP_P_LO, OP_P_LOW, OP_P_HI, OP_P_HIW,
    OP_P_LEN, OP_P_N0, OP_P_SUM, OP_P_META, OP_P_WT, OP_P_WTW, OP_P_NEXT,
    OP_P_OK, OP_P_FAIL,
    OP_R_CHK, OP_R_MH, OP_R_MV, OP_R_VW, OP_R_VL, OP_R_HRUN, OP_R_VMAC,
    OP_R_DONE, OP_FIN
  } op_t;

  typedef struct packed {
    logic [1:0] act;
    logic       size_bad;
    logic       taps_bad;
    logic       len_bad;
    logic       div_done;
    logic       sum_end;
    logic       wt_end;
    logic       need_div;
    logic       idx_last;
    logic       rd_bad;
    logic       v_end;
    logic       h_end;
    logic       out_free;
  } dp_stat_t;

endpackage

/* src/separable_triangle_resampler.sv */
// ----------------------------------------------------------------------------
// separable_triangle_resampler
// Antialiased triangle-filter resize of a square RGB window, one word at a time.
// ----------------------------------------------------------------------------
// One request word is taken at a time; the next is accepted once the current
// result has moved to the output register. A read runs, for each tap of the
// output row, a horizontal multiply-accumulate pass over the window memory
// port followed by one vertical accumulate step. A prepare runs through the
// shared bit-serial divider: per output index two coordinate divisions and
// one division per nonzero-sum tap weight, each resolving one quotient bit
// per cycle (33-bit dividend at default sizes).
module separable_triangle_resampler #(
  parameter int MAX_WINDOW       = 128,
  parameter int MAX_OUT          = 64,
  parameter int MAX_TAPS         = 17,
  parameter int WEIGHT_FRAC_BITS = 22
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [6:0]        in_row,
  input  logic [6:0]        in_col,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic signed [7:0] out_red,
  output logic signed [7:0] out_green,
  output logic signed [7:0] out_blue,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata
);

  str_pkg::op_t      op;
  str_pkg::dp_stat_t stat;

  str_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  str_dp #(
    .MAX_WINDOW       (MAX_WINDOW),
    .MAX_OUT          (MAX_OUT),
    .MAX_TAPS         (MAX_TAPS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .stat       (stat),
    .in_action  (in_action),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Only one request word is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // Anything but a good result carries zero samples.
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != str_pkg::ST_OK) |->
      (out_red == 8'sd0) && (out_green == 8'sd0) && (out_blue == 8'sd0))
    else $error("nonzero samples on a failed result");

  // A result appears only while a request is in progress.
  a_result_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a request in progress");

endmodule

/* src/str_div.sv */
// ----------------------------------------------------------------------------
// str_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module str_div #(
  parameter int NW = 33,
  parameter int DW = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_r;
  logic [NW-1:0]    q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DW-1:0]    den_r;
  logic [DW:0]      rem2;
  logic             ge;

  assign rem2 = {rem_r, q_r[NW-1]};
  assign ge   = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(NW);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? DW'(rem2 - {1'b0, den_r}) : rem2[DW-1:0];
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

/* src/str_dp.sv */
// ----------------------------------------------------------------------------
// str_dp
// Datapath: window, tap and weight memories, tap table arithmetic, the shared
// divider, the multiply-accumulate passes and the result register.
// ----------------------------------------------------------------------------
module str_dp #(
  parameter int MAX_WINDOW       = 128,
  parameter int MAX_OUT          = 64,
  parameter int MAX_TAPS         = 17,
  parameter int WEIGHT_FRAC_BITS = 22
) (
  input  logic              clk,
  input  logic              rst_n,
  input  str_pkg::op_t      op,
  output str_pkg::dp_stat_t stat,
  input  logic [1:0]        in_action,
  input  logic [6:0]        in_row,
  input  logic [6:0]        in_col,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic signed [7:0] out_red,
  output logic signed [7:0] out_green,
  output logic signed [7:0] out_blue,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata
);

  localparam int F      = WEIGHT_FRAC_BITS;
  localparam int WIN_AW = $clog2(MAX_WINDOW);
  localparam int OUT_AW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int TC_W   = $clog2(MAX_TAPS + 1);
  localparam int WT_AW  = $clog2(MAX_OUT * MAX_TAPS);
  localparam int PIX_AW = $clog2(MAX_WINDOW * MAX_WINDOW);
  localparam int WT_W   = F + 1;
  localparam int KW     = $clog2(2 * MAX_WINDOW + 1);
  localparam int SUM_W  = KW + $clog2(MAX_TAPS + 1);
  localparam int CW0    = $clog2(4 * MAX_OUT * MAX_WINDOW + 4 * MAX_WINDOW) + 2;
  localparam int CW     = (CW0 < 12) ? 12 : CW0;
  localparam int DVA    = KW + F + 2;
  localparam int DVD_W  = (DVA > CW) ? DVA : CW;
  localparam int DVS_W  = (SUM_W + 1 > 9) ? SUM_W + 1 : 9;
  localparam int ACC_W  = F + 10;
  localparam int META_W = WIN_AW + TC_W;

  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (F - 1);

  function automatic logic [7:0] clip8(input logic [ACC_W-1:0] a);
    clip8 = (|a[ACC_W-1:F+8]) ? 8'hFF : a[F+7:F];
  endfunction

  // Configuration and latched request
  logic [7:0] w_r;
  logic [6:0] o_r;
  logic       prepared_r;
  logic [1:0] act_r;
  logic [6:0] row_r, col_r;
  logic [23:0] rgb_r;

  // Table build state
  logic signed [CW-1:0] s_r, sup_r, c_r, lo_r, hi_r, len_r, prod_r, n_r;
  logic                 lo_neg_r;
  logic [SUM_W-1:0]     sum_r;
  logic [OUT_AW-1:0]    i_r;
  logic [WT_AW-1:0]     wbase_r;
  logic [TC_W-1:0]      t_r;

  // Read state
  logic [WIN_AW-1:0] first_h_r, first_v_r;
  logic [TC_W-1:0]   cnt_h_r, cnt_v_r, u_r;
  logic [WT_AW-1:0]  hbase_r, vbase_r;
  logic [PIX_AW-1:0] rbase_r;
  logic [WT_W-1:0]   vwt_r;
  logic              mac_v_r;
  logic [ACC_W-1:0]  hacc_r [3];
  logic [ACC_W-1:0]  vacc_r [3];

  // Result and output registers
  logic [1:0] res_status_r;
  logic [7:0] res_r [3];
  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [7:0] out_px_r [3];

  // Memories
  logic [23:0]     win_mem [MAX_WINDOW*MAX_WINDOW];
  logic [WT_W-1:0] wt_mem [MAX_OUT*MAX_TAPS];
  logic [META_W-1:0] meta_mem [MAX_OUT];
  logic [23:0]       win_q_r;
  logic [WT_W-1:0]   wt_q_r;
  logic [META_W-1:0] meta_q_r;

  logic              win_we, wt_we, meta_we;
  logic [PIX_AW-1:0] win_waddr, win_raddr;
  logic [WT_AW-1:0]  wt_waddr, wt_raddr;
  logic [WT_W-1:0]   wt_wdata;
  logic [OUT_AW-1:0] meta_raddr;

  // Divider
  logic             div_start, div_done;
  logic [DVD_W-1:0] div_num, div_q;
  logic [DVS_W-1:0] div_den;

  logic signed [CW-1:0] w_s, o_s, taps_s, lo_num, hi_num, abs_n, k_s, t_s;
  logic [KW-1:0]        k;
  logic                 size_bad, wr_ok, rd_bad, need_div, wt_end, h_end;

  assign w_s    = $signed(CW'(w_r));
  assign o_s    = $signed(CW'(o_r));
  assign taps_s = (sup_r <<< 1) + CW'(1);
  assign lo_num = c_r - s_r + o_s;
  assign hi_num = c_r + s_r + o_s;
  assign abs_n  = (n_r < 0) ? -n_r : n_r;
  assign k_s    = (abs_n < s_r) ? s_r - abs_n : '0;
  assign k      = k_s[KW-1:0];
  assign t_s    = $signed(CW'(t_r));

  assign size_bad = (w_r == 8'd0) || (32'(w_r) > MAX_WINDOW) ||
                    (o_r == 7'd0) || (32'(o_r) > MAX_OUT);
  assign wr_ok    = ({1'b0, row_r} < w_r) && ({1'b0, col_r} < w_r) &&
                    (32'(row_r) < MAX_WINDOW) && (32'(col_r) < MAX_WINDOW);
  assign rd_bad   = !prepared_r || (row_r >= o_r) || (col_r >= o_r) ||
                    (32'(row_r) >= MAX_OUT) || (32'(col_r) >= MAX_OUT);
  assign need_div = (t_s < len_r) && (sum_r != '0);
  assign wt_end   = (32'(t_r) == MAX_TAPS);
  assign h_end    = (u_r == cnt_h_r);

  always_comb begin
    stat.act      = act_r;
    stat.size_bad = size_bad;
    stat.taps_bad = taps_s > $signed(CW'(MAX_TAPS));
    stat.len_bad  = (len_r <= 0) || (len_r > taps_s);
    stat.div_done = div_done;
    stat.sum_end  = (t_s == len_r);
    stat.wt_end   = wt_end;
    stat.need_div = need_div;
    stat.idx_last = ($signed(CW'(i_r)) == o_s - CW'(1));
    stat.rd_bad   = rd_bad;
    stat.v_end    = (t_r == cnt_v_r);
    stat.h_end    = h_end;
    stat.out_free = !out_valid_r || out_ready;
  end

  // Divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DVS_W'(o_r);
    case (op)
      str_pkg::OP_P_CHK: begin
        div_start = 1'b1;
        div_num   = DVD_W'(w_r) + DVD_W'(o_r) - DVD_W'(1);
        div_den   = DVS_W'(o_r);
      end
      str_pkg::OP_P_LO: begin
        div_start = 1'b1;
        div_num   = (lo_num < 0) ? '0 : DVD_W'($unsigned(lo_num));
        div_den   = DVS_W'({o_r, 1'b0});
      end
      str_pkg::OP_P_HI: begin
        div_start = 1'b1;
        div_num   = DVD_W'($unsigned(hi_num));
        div_den   = DVS_W'({o_r, 1'b0});
      end
      str_pkg::OP_P_WT: begin
        div_start = !wt_end && need_div;
        div_num   = (DVD_W'(k) << (F + 1)) + DVD_W'(sum_r);
        div_den   = DVS_W'({sum_r, 1'b0});
      end
      default: ;
    endcase
  end

  str_div #(.NW(DVD_W), .DW(DVS_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  // Memory port selection
  always_comb begin
    win_we     = (op == str_pkg::OP_WRITE) && wr_ok;
    win_waddr  = PIX_AW'(32'(row_r) * MAX_WINDOW + 32'(col_r));
    win_raddr  = PIX_AW'(rbase_r + PIX_AW'(first_h_r) + PIX_AW'(u_r));
    wt_waddr   = WT_AW'(wbase_r + WT_AW'(t_r));
    wt_we      = 1'b0;
    wt_wdata   = '0;
    if (op == str_pkg::OP_P_WT && !wt_end && !need_div) begin
      wt_we = 1'b1;
    end else if (op == str_pkg::OP_P_WTW && div_done) begin
      wt_we    = 1'b1;
      wt_wdata = div_q[WT_W-1:0];
    end
    wt_raddr   = (op == str_pkg::OP_R_VW) ? WT_AW'(vbase_r + WT_AW'(t_r))
                                          : WT_AW'(hbase_r + WT_AW'(u_r));
    meta_we    = (op == str_pkg::OP_P_META);
    meta_raddr = (op == str_pkg::OP_R_CHK) ? OUT_AW'(col_r) : OUT_AW'(row_r);
  end

  always_ff @(posedge clk) begin
    if (win_we) win_mem[win_waddr] <= rgb_r;
    win_q_r <= win_mem[win_raddr];
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[wt_waddr] <= wt_wdata;
    wt_q_r <= wt_mem[wt_raddr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[i_r] <= {lo_r[WIN_AW-1:0], len_r[TC_W-1:0]};
    meta_q_r <= meta_mem[meta_raddr];
  end

  // Configuration registers and prepared flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r        <= 8'd128;
      o_r        <= 7'd64;
      prepared_r <= 1'b0;
    end else begin
      if (op == str_pkg::OP_P_OK) prepared_r <= 1'b1;
      if (op == str_pkg::OP_P_FAIL) prepared_r <= 1'b0;
      if (cfg_we) begin
        prepared_r <= 1'b0;
        if (cfg_index == str_pkg::REG_OUT) o_r <= cfg_wdata[6:0];
        else                               w_r <= cfg_wdata;
      end
    end
  end

  // Table build and read sequencing registers
  always_ff @(posedge clk) begin
    case (op)
      str_pkg::OP_LATCH: begin
        act_r <= in_action;
        row_r <= in_row;
        col_r <= in_col;
        rgb_r <= {in_red, in_green, in_blue};
      end
      str_pkg::OP_P_CHK: s_r <= (w_r >= {1'b0, o_r}) ? (w_s <<< 1) : (o_s <<< 1);
      str_pkg::OP_P_SUP: if (div_done) begin
        sup_r <= (w_r >= {1'b0, o_r}) ? $signed(CW'(div_q)) : CW'(1);
      end
      str_pkg::OP_P_TAPS: begin
        i_r     <= '0;
        c_r     <= w_s;
        wbase_r <= '0;
      end
      str_pkg::OP_P_LO: lo_neg_r <= (lo_num < 0);
      str_pkg::OP_P_LOW: if (div_done) begin
        lo_r <= lo_neg_r ? '0 : $signed(CW'(div_q));
      end
      str_pkg::OP_P_HIW: if (div_done) begin
        hi_r <= (div_q > DVD_W'(w_r)) ? w_s : $signed(CW'(div_q));
      end
      str_pkg::OP_P_LEN: begin
        len_r  <= hi_r - lo_r;
        prod_r <= CW'(((lo_r <<< 1) + CW'(1)) * o_s);
      end
      str_pkg::OP_P_N0: begin
        n_r   <= prod_r - c_r;
        t_r   <= '0;
        sum_r <= '0;
      end
      str_pkg::OP_P_SUM: if (t_s != len_r) begin
        sum_r <= sum_r + SUM_W'(k);
        n_r   <= n_r + (o_s <<< 1);
        t_r   <= t_r + 1'b1;
      end
      str_pkg::OP_P_META: begin
        n_r <= prod_r - c_r;
        t_r <= '0;
      end
      str_pkg::OP_P_WT: if (!wt_end && !need_div) begin
        t_r <= t_r + 1'b1;
        n_r <= n_r + (o_s <<< 1);
      end
      str_pkg::OP_P_WTW: if (div_done) begin
        t_r <= t_r + 1'b1;
        n_r <= n_r + (o_s <<< 1);
      end
      str_pkg::OP_P_NEXT: begin
        i_r     <= i_r + 1'b1;
        c_r     <= c_r + (w_s <<< 1);
        wbase_r <= WT_AW'(wbase_r + WT_AW'(MAX_TAPS));
      end
      str_pkg::OP_R_CHK: begin
        hbase_r <= WT_AW'(32'(col_r) * MAX_TAPS);
        vbase_r <= WT_AW'(32'(row_r) * MAX_TAPS);
      end
      str_pkg::OP_R_MH: begin
        first_h_r <= meta_q_r[META_W-1:TC_W];
        cnt_h_r   <= meta_q_r[TC_W-1:0];
      end
      str_pkg::OP_R_MV: begin
        first_v_r <= meta_q_r[META_W-1:TC_W];
        cnt_v_r   <= meta_q_r[TC_W-1:0];
        t_r       <= '0;
      end
      str_pkg::OP_R_VW:
        rbase_r <= PIX_AW'((32'(first_v_r) + 32'(t_r)) * MAX_WINDOW);
      str_pkg::OP_R_VL: begin
        vwt_r <= wt_q_r;
        u_r   <= '0;
      end
      str_pkg::OP_R_HRUN: if (!h_end) u_r <= u_r + 1'b1;
      str_pkg::OP_R_VMAC: t_r <= t_r + 1'b1;
      default: ;
    endcase
  end

  // Multiply-accumulate passes; the window read data is registered and lands in the cycle after issue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_v_r <= 1'b0;
    end else begin
      mac_v_r <= (op == str_pkg::OP_R_HRUN) && !h_end;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (op == str_pkg::OP_R_VL) begin
        hacc_r[ch] <= HALF;
      end else if (mac_v_r) begin
        hacc_r[ch] <= hacc_r[ch] + ACC_W'(wt_q_r) * ACC_W'(win_q_r[16-8*ch +: 8]);
      end
      if (op == str_pkg::OP_R_MV) begin
        vacc_r[ch] <= HALF;
      end else if (op == str_pkg::OP_R_VMAC) begin
        vacc_r[ch] <= vacc_r[ch] + ACC_W'(vwt_r) * ACC_W'(clip8(hacc_r[ch]));
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    case (op)
      str_pkg::OP_BAD: begin
        res_status_r <= str_pkg::ST_BADREQ;
        for (int ch = 0; ch < 3; ch++) res_r[ch] <= 8'd0;
      end
      str_pkg::OP_WRITE: begin
        res_status_r <= wr_ok ? str_pkg::ST_OK : str_pkg::ST_BADREQ;
        for (int ch = 0; ch < 3; ch++) res_r[ch] <= 8'd0;
      end
      str_pkg::OP_P_OK: begin
        res_status_r <= str_pkg::ST_OK;
        for (int ch = 0; ch < 3; ch++) res_r[ch] <= 8'd0;
      end
      str_pkg::OP_P_FAIL: begin
        res_status_r <= str_pkg::ST_REJECT;
        for (int ch = 0; ch < 3; ch++) res_r[ch] <= 8'd0;
      end
      str_pkg::OP_R_DONE: begin
        res_status_r <= str_pkg::ST_OK;
        for (int ch = 0; ch < 3; ch++) res_r[ch] <= clip8(vacc_r[ch]) ^ 8'h80;
      end
      default: ;
    endcase
  end

  // Output register parts the result side from the request side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == str_pkg::OP_FIN && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == str_pkg::OP_FIN && (!out_valid_r || out_ready)) begin
      out_status_r <= res_status_r;
      for (int ch = 0; ch < 3; ch++) out_px_r[ch] <= res_r[ch];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_red    = $signed(out_px_r[0]);
  assign out_green  = $signed(out_px_r[1]);
  assign out_blue   = $signed(out_px_r[2]);

endmodule

/* src/str_ctrl.sv */
// ----------------------------------------------------------------------------
// str_ctrl
// Controller: sequences accept, table build, pixel write, pixel read and
// result hand-off by issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module str_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  str_pkg::dp_stat_t stat,
  output str_pkg::op_t      op
);

  typedef enum logic [28:0] {
    S_IDLE  = 29'h0000001, S_DISP  = 29'h0000002, S_BAD   = 29'h0000004,
    S_WR    = 29'h0000008, S_PCHK  = 29'h0000010, S_PSUP  = 29'h0000020,
    S_PTAPS = 29'h0000040, S_PLO   = 29'h0000080, S_PLOW  = 29'h0000100,
    S_PHI   = 29'h0000200, S_PHIW  = 29'h0000400, S_PLEN  = 29'h0000800,
    S_PN0   = 29'h0001000, S_PSUM  = 29'h0002000, S_PMETA = 29'h0004000,
    S_PWT   = 29'h0008000, S_PWTW  = 29'h0010000, S_PNEXT = 29'h0020000,
    S_POK   = 29'h0040000, S_PFAIL = 29'h0080000, S_RCHK  = 29'h0100000,
    S_RMH   = 29'h0200000, S_RMV   = 29'h0400000, S_RVW   = 29'h0800000,
    S_RVL   = 29'h1000000, S_RHRUN = 29'h2000000, S_RVMAC = 29'h4000000,
    S_RDONE = 29'h8000000, S_FIN   = 29'h10000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = str_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        op        = str_pkg::OP_LATCH;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        unique case (stat.act)
          str_pkg::ACT_PREPARE: state_nxt = S_PCHK;
          str_pkg::ACT_WRITE:   state_nxt = S_WR;
          str_pkg::ACT_READ:    state_nxt = S_RCHK;
          default:              state_nxt = S_BAD;
        endcase
      end
      S_BAD: begin
        op        = str_pkg::OP_BAD;
        state_nxt = S_FIN;
      end
      S_WR: begin
        op        = str_pkg::OP_WRITE;
        state_nxt = S_FIN;
      end
      S_PCHK: begin
        op        = str_pkg::OP_P_CHK;
        state_nxt = stat.size_bad ? S_PFAIL : S_PSUP;
      end
      S_PSUP: begin
        op = str_pkg::OP_P_SUP;
        if (stat.div_done) state_nxt = S_PTAPS;
      end
      S_PTAPS: begin
        op        = str_pkg::OP_P_TAPS;
        state_nxt = stat.taps_bad ? S_PFAIL : S_PLO;
      end
      S_PLO: begin
        op        = str_pkg::OP_P_LO;
        state_nxt = S_PLOW;
      end
      S_PLOW: begin
        op = str_pkg::OP_P_LOW;
        if (stat.div_done) state_nxt = S_PHI;
      end
      S_PHI: begin
        op        = str_pkg::OP_P_HI;
        state_nxt = S_PHIW;
      end
      S_PHIW: begin
        op = str_pkg::OP_P_HIW;
        if (stat.div_done) state_nxt = S_PLEN;
      end
      S_PLEN: begin
        op        = str_pkg::OP_P_LEN;
        state_nxt = S_PN0;
      end
      S_PN0: begin
        op        = str_pkg::OP_P_N0;
        state_nxt = stat.len_bad ? S_PFAIL : S_PSUM;
      end
      S_PSUM: begin
        op = str_pkg::OP_P_SUM;
        if (stat.sum_end) state_nxt = S_PMETA;
      end
      S_PMETA: begin
        op        = str_pkg::OP_P_META;
        state_nxt = S_PWT;
      end
      S_PWT: begin
        op = str_pkg::OP_P_WT;
        if (stat.wt_end)        state_nxt = S_PNEXT;
        else if (stat.need_div) state_nxt = S_PWTW;
      end
      S_PWTW: begin
        op = str_pkg::OP_P_WTW;
        if (stat.div_done) state_nxt = S_PWT;
      end
      S_PNEXT: begin
        op        = str_pkg::OP_P_NEXT;
        state_nxt = stat.idx_last ? S_POK : S_PLO;
      end
      S_POK: begin
        op        = str_pkg::OP_P_OK;
        state_nxt = S_FIN;
      end
      S_PFAIL: begin
        op        = str_pkg::OP_P_FAIL;
        state_nxt = S_FIN;
      end
      S_RCHK: begin
        op        = str_pkg::OP_R_CHK;
        state_nxt = stat.rd_bad ? S_BAD : S_RMH;
      end
      S_RMH: begin
        op        = str_pkg::OP_R_MH;
        state_nxt = S_RMV;
      end
      S_RMV: begin
        op        = str_pkg::OP_R_MV;
        state_nxt = S_RVW;
      end
      S_RVW: begin
        op        = str_pkg::OP_R_VW;
        state_nxt = stat.v_end ? S_RDONE : S_RVL;
      end
      S_RVL: begin
        op        = str_pkg::OP_R_VL;
        state_nxt = S_RHRUN;
      end
      S_RHRUN: begin
        op = str_pkg::OP_R_HRUN;
        if (stat.h_end) state_nxt = S_RVMAC;
      end
      S_RVMAC: begin
        op        = str_pkg::OP_R_VMAC;
        state_nxt = S_RVW;
      end
      S_RDONE: begin
        op        = str_pkg::OP_R_DONE;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        op = str_pkg::OP_FIN;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Triangle resampler testbench
// Drives prepare, pixel-write, pixel-read and unknown-action words and register
// writes into the resampler under several window/output sizes and compares every
// result word with a scoreboard model of the tap table and of both filter passes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_MAX    = 128;
  localparam int OUT_MAX    = 64;
  localparam int TAPS_MAX   = 17;
  localparam int FRAC       = 22;
  localparam int IDLE_LIMIT = 200000;

  typedef struct {
    logic [1:0] st;
    logic [7:0] r, g, b;
  } px_result_t;

  class resample_scoreboard;
    logic [23:0] pix [WIN_MAX*WIN_MAX];
    bit          written [WIN_MAX*WIN_MAX];
    int          tstart [OUT_MAX];
    int          tcnt [OUT_MAX];
    longint      wt [OUT_MAX*TAPS_MAX];
    bit          prepared;
    int          wsize = 128;
    int          osize = 64;
    px_result_t  pending [$];
    int          mismatches, checked, good_reads, rejects;

    function void set_cfg(bit idx, logic [7:0] v);
      if (idx == str_pkg::REG_WINDOW) wsize = int'(v);
      else osize = int'(v[6:0]);
      prepared = 0;
    endfunction

    function int build_taps();
      longint w, o, s, sup, taps, c, lo, hi, len, sum, n, a, v;
      longint k [TAPS_MAX];
      w = wsize;
      o = osize;
      if (w < 1 || w > WIN_MAX || o < 1 || o > OUT_MAX) return 1;
      if (w >= o) begin
        s = 2 * w;
        sup = (w + o - 1) / o;
      end else begin
        s = 2 * o;
        sup = 1;
      end
      taps = 2 * sup + 1;
      if (taps > TAPS_MAX) return 1;
      for (int i = 0; i < o; i++) begin
        c = (2 * i + 1) * w;
        lo = c - s + o;
        lo = (lo < 0) ? 0 : lo / (2 * o);
        hi = (c + s + o) / (2 * o);
        if (hi > w) hi = w;
        len = hi - lo;
        if (len <= 0 || len > taps) return 1;
        sum = 0;
        for (int t = 0; t < len; t++) begin
          n = (2 * (lo + t) + 1) * o - c;
          a = n < 0 ? -n : n;
          k[t] = a < s ? s - a : 0;
          sum += k[t];
        end
        tstart[i] = int'(lo);
        tcnt[i] = int'(len);
        for (int t = 0; t < TAPS_MAX; t++) begin
          v = 0;
          if (t < len && sum != 0) v = (2 * k[t] * (64'd1 << FRAC) + sum) / (2 * sum);
          wt[i*TAPS_MAX+t] = v;
        end
      end
      return 0;
    endfunction

    function logic [7:0] clip(longint acc);
      longint v;
      v = acc >> FRAC;
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // One horizontal pass over window row r for output column oc.
    function logic [23:0] hpass(int r, int oc);
      longint acc [3];
      logic [23:0] px, res;
      int x;
      for (int ch = 0; ch < 3; ch++) acc[ch] = 64'd1 << (FRAC - 1);
      for (int t = 0; t < tcnt[oc]; t++) begin
        x = tstart[oc] + t;
        px = (x < WIN_MAX && r < WIN_MAX) ? pix[r*WIN_MAX+x] : 24'd0;
        for (int ch = 0; ch < 3; ch++)
          acc[ch] += wt[oc*TAPS_MAX+t] * px[16-8*ch +: 8];
      end
      for (int ch = 0; ch < 3; ch++) res[16-8*ch +: 8] = clip(acc[ch]);
      return res;
    endfunction

    function void note_input(logic [1:0] act, logic [6:0] row, logic [6:0] col,
                             logic [7:0] red, logic [7:0] grn, logic [7:0] blu);
      px_result_t e;
      logic [23:0] res, h;
      longint acc [3];
      e.st = str_pkg::ST_OK;
      res = 24'h808080;
      if (act == str_pkg::ACT_PREPARE) begin
        if (build_taps() == 0) prepared = 1;
        else begin
          prepared = 0;
          e.st = str_pkg::ST_REJECT;
        end
      end else if (act == str_pkg::ACT_WRITE) begin
        if (row < wsize && col < wsize) begin
          pix[row*WIN_MAX+col] = {red, grn, blu};
          written[row*WIN_MAX+col] = 1;
        end else e.st = str_pkg::ST_BADREQ;
      end else if (act == str_pkg::ACT_READ) begin
        if (prepared && row < osize && col < osize && row < OUT_MAX && col < OUT_MAX) begin
          for (int ch = 0; ch < 3; ch++) acc[ch] = 64'd1 << (FRAC - 1);
          for (int t = 0; t < tcnt[row]; t++) begin
            h = hpass(tstart[row] + t, col);
            for (int ch = 0; ch < 3; ch++)
              acc[ch] += wt[row*TAPS_MAX+t] * h[16-8*ch +: 8];
          end
          for (int ch = 0; ch < 3; ch++) res[16-8*ch +: 8] = clip(acc[ch]);
          good_reads++;
        end else e.st = str_pkg::ST_BADREQ;
      end else e.st = str_pkg::ST_BADREQ;
      if (e.st == str_pkg::ST_REJECT) rejects++;
      e.r = res[23:16] ^ 8'h80;
      e.g = res[15:8] ^ 8'h80;
      e.b = res[7:0] ^ 8'h80;
      pending.push_back(e);
    endfunction

    function void check_result(px_result_t got);
      px_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word st=%0d", got.st);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.st !== e.st || got.r !== e.r || got.g !== e.g || got.b !== e.b) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch word %0d: exp st=%0d rgb=%h %h %h, got st=%0d rgb=%h %h %h",
                   checked, e.st, e.r, e.g, e.b, got.st, got.r, got.g, got.b);
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_valid = 0;
  logic              in_ready;
  logic [1:0]        in_action = '0;
  logic [6:0]        in_row = '0;
  logic [6:0]        in_col = '0;
  logic [7:0]        in_red = '0;
  logic [7:0]        in_green = '0;
  logic [7:0]        in_blue = '0;
  logic              out_valid;
  logic              out_ready = 0;
  logic [1:0]        out_status;
  logic signed [7:0] out_red, out_green, out_blue;
  logic              cfg_we = 0;
  logic              cfg_index = 0;
  logic [7:0]        cfg_wdata = '0;

  resample_scoreboard sb = new();
  int send_idle_pct, recv_stall_pct, words_sent, idle_cycles;

  separable_triangle_resampler dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_status, out_red, out_green, out_blue});
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(logic [1:0] act, logic [6:0] row, logic [6:0] col,
                      logic [7:0] red, logic [7:0] grn, logic [7:0] blu);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_row <= row;
    in_col <= col;
    in_red <= red;
    in_green <= grn;
    in_blue <= blu;
    do @(posedge clk); while (!in_ready);
    sb.note_input(act, row, col, red, grn, blu);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(bit idx, logic [7:0] v);
    wait_drained();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_cfg(idx, v);
  endtask

  task automatic write_px(int row, int col);
    send(str_pkg::ACT_WRITE, 7'(row), 7'(col), 8'($urandom_range(255)),
         8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // For an in-range prepared read, every window pixel under its taps is written first.
  task automatic read_px(logic [6:0] row, logic [6:0] col);
    if (sb.prepared && row < sb.osize && col < sb.osize) begin
      for (int y = sb.tstart[row]; y < sb.tstart[row] + sb.tcnt[row]; y++)
        for (int x = sb.tstart[col]; x < sb.tstart[col] + sb.tcnt[col]; x++)
          if (!sb.written[y*WIN_MAX+x]) write_px(y, x);
    end
    send(str_pkg::ACT_READ, row, col, 8'($urandom_range(255)),
         8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic random_word();
    int p;
    p = $urandom_range(99);
    if (p < 2) send(str_pkg::ACT_RESERVED, 7'($urandom), 7'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
    else if (p < 4 && sb.osize <= 16)
      send(str_pkg::ACT_PREPARE, 7'($urandom), 7'($urandom), 8'd0, 8'd0, 8'd0);
    else if (p < 45) begin
      if ($urandom_range(9) != 0) write_px($urandom_range(sb.wsize - 1), $urandom_range(sb.wsize - 1));
      else write_px($urandom_range(127), $urandom_range(127));
    end else if (!sb.prepared || $urandom_range(9) == 0) read_px(7'($urandom), 7'($urandom));
    else read_px(7'($urandom_range(sb.osize - 1)), 7'($urandom_range(sb.osize - 1)));
  endtask

  initial begin
    int wl [9] = '{16, 8, 64, 3, 32, 1, 128, 5, 20};
    int ol [9] = '{8, 16, 8, 64, 32, 1, 16, 3, 7};
    int seg_start;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: unprepared read, unknown action, rejected sizes and tap counts.
    read_px(7'd0, 7'd0);
    send(str_pkg::ACT_RESERVED, 7'h7f, 7'h7f, 8'hff, 8'hff, 8'hff);
    cfg_write(str_pkg::REG_WINDOW, 8'd0);
    send(str_pkg::ACT_PREPARE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
    cfg_write(str_pkg::REG_WINDOW, 8'd255);
    send(str_pkg::ACT_PREPARE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
    cfg_write(str_pkg::REG_WINDOW, 8'd128);
    cfg_write(str_pkg::REG_OUT, 8'd0);
    send(str_pkg::ACT_PREPARE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
    cfg_write(str_pkg::REG_OUT, 8'd100);
    send(str_pkg::ACT_PREPARE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
    cfg_write(str_pkg::REG_OUT, 8'd1);
    send(str_pkg::ACT_PREPARE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
    // Smallest useful table, extreme sample values, out-of-range coordinates.
    cfg_write(str_pkg::REG_WINDOW, 8'd2);
    send(str_pkg::ACT_PREPARE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
    send(str_pkg::ACT_WRITE, 7'd0, 7'd0, 8'hff, 8'hff, 8'hff);
    send(str_pkg::ACT_WRITE, 7'd0, 7'd1, 8'h00, 8'h00, 8'h00);
    send(str_pkg::ACT_WRITE, 7'd1, 7'd0, 8'hff, 8'h00, 8'hff);
    send(str_pkg::ACT_WRITE, 7'd1, 7'd1, 8'h00, 8'hff, 8'h00);
    send(str_pkg::ACT_WRITE, 7'd2, 7'd0, 8'h12, 8'h34, 8'h56);
    send(str_pkg::ACT_WRITE, 7'h7f, 7'h7f, 8'h12, 8'h34, 8'h56);
    read_px(7'd0, 7'd0);
    read_px(7'd1, 7'd0);
    read_px(7'd0, 7'h7f);
    // A register write drops the table even with an unchanged value.
    cfg_write(str_pkg::REG_OUT, 8'd1);
    read_px(7'd0, 7'd0);

    for (int seg = 0; seg < 9; seg++) begin
      send_idle_pct = (seg < 3) ? 31 : (seg < 6) ? 54 : 0;
      recv_stall_pct = (seg < 3) ? 54 : (seg < 6) ? 31 : 0;
      cfg_write(str_pkg::REG_WINDOW, 8'(wl[seg]));
      cfg_write(str_pkg::REG_OUT, 8'(ol[seg]));
      send(str_pkg::ACT_PREPARE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
      seg_start = words_sent;
      while (words_sent - seg_start < 195) random_word();
    end

    wait_drained();
    repeat (400) @(posedge clk);
    $display("covered %0d words: %0d filtered reads, %0d rejected prepares, 9 size settings",
             words_sent, sb.good_reads, sb.rejects);
    $display("%0d result words compared, %0d mismatches, %0d left pending",
             sb.checked, sb.mismatches, sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* filelist.f */
src/str_pkg.sv
src/str_div.sv
src/str_dp.sv
src/str_ctrl.sv
src/separable_triangle_resampler.sv
dv/testbench.sv
